// ----- src/rfp_pkg.sv -----
`timescale 1ns / 1ps

package rfp_pkg;

	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] TYPE_INT_A   = 8'hA1;
	localparam logic [7:0] TYPE_FLOAT_A = 8'hA2;
	localparam logic [7:0] TYPE_STR_A   = 8'hA3;
	localparam logic [7:0] TYPE_INT_B   = 8'hB1;
	localparam logic [7:0] TYPE_FLOAT_B = 8'hB2;
	localparam logic [7:0] TYPE_STR_B   = 8'hB3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_CRC_BAD = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;

	localparam logic KIND_STRING  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} in_beat_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  string_byte;
		logic [7:0]  addr_byte;
		logic [7:0]  func_byte;
		logic [7:0]  type_code;
		logic [31:0] number_value;
		logic [7:0]  string_length;
		logic [1:0]  status;
		logic        last;
	} result_t;

	function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic logic is_number_type(logic [7:0] t);
		return (t == TYPE_INT_A) || (t == TYPE_INT_B) ||
			(t == TYPE_FLOAT_A) || (t == TYPE_FLOAT_B);
	endfunction

	function automatic logic is_string_type(logic [7:0] t);
		return (t == TYPE_STR_A) || (t == TYPE_STR_B);
	endfunction

endpackage

// ----- src/rfp_in_reg.sv -----
`timescale 1ns / 1ps

module rfp_in_reg
	import rfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] rx_byte,
	input  logic       frame_start,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       take,
	output logic       valid_s1,
	output in_beat_t   beat_s1
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_s1.rx_byte     <= rx_byte;
			beat_s1.frame_start <= frame_start;
		end
	end

endmodule

// ----- src/rfp_parser.sv -----
`timescale 1ns / 1ps

module rfp_parser
	import rfp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  in_beat_t beat,
	output logic     res_valid,
	output result_t  res
);

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_FUNC  = 3'd1;
	localparam logic [2:0] PH_TYPE  = 3'd2;
	localparam logic [2:0] PH_VALUE = 3'd3;
	localparam logic [2:0] PH_LEN   = 3'd4;
	localparam logic [2:0] PH_STR   = 3'd5;
	localparam logic [2:0] PH_CRCLO = 3'd6;
	localparam logic [2:0] PH_CRCHI = 3'd7;

	logic [2:0]  phase_q,  phase_d;
	logic [15:0] crc_q,    crc_d;
	logic [7:0]  left_q,   left_d;
	logic [7:0]  addr_q,   addr_d;
	logic [7:0]  func_q,   func_d;
	logic [7:0]  type_q,   type_d;
	logic [31:0] value_q,  value_d;
	logic [7:0]  len_q,    len_d;
	logic [7:0]  crclo_q,  crclo_d;
	logic [15:0] crc_next;
	logic [7:0]  b;
	logic        is_num;
	logic        is_str;
	logic        kind;
	logic [7:0]  sbyte;
	logic [1:0]  status;

	assign b        = beat.rx_byte;
	assign crc_next = crc_step(beat.frame_start ? 16'h0000 : crc_q, b);

	always_comb begin
		phase_d   = phase_q;
		crc_d     = crc_q;
		left_d    = left_q;
		addr_d    = addr_q;
		func_d    = func_q;
		type_d    = type_q;
		value_d   = value_q;
		len_d     = len_q;
		crclo_d   = crclo_q;
		res_valid = 1'b0;
		kind      = KIND_SUMMARY;
		sbyte     = 8'h00;
		status    = ST_OK;
		if (beat.frame_start) begin
			addr_d  = b;
			func_d  = 8'h00;
			type_d  = 8'h00;
			value_d = 32'h0;
			len_d   = 8'h00;
			left_d  = 8'h00;
			crclo_d = 8'h00;
			crc_d   = crc_next;
			phase_d = PH_FUNC;
		end else begin
			case (phase_q)
				PH_FUNC: begin
					func_d  = b;
					crc_d   = crc_next;
					phase_d = PH_TYPE;
				end
				PH_TYPE: begin
					type_d = b;
					crc_d  = crc_next;
					if (is_number_type(b)) begin
						value_d = 32'h0;
						left_d  = 8'd4;
						phase_d = PH_VALUE;
					end else if (is_string_type(b)) begin
						phase_d = PH_LEN;
					end else begin
						phase_d   = PH_IDLE;
						res_valid = 1'b1;
						status    = ST_UNKNOWN;
					end
				end
				PH_VALUE: begin
					value_d = {value_q[23:0], b};
					crc_d   = crc_next;
					left_d  = left_q - 8'd1;
					if (left_q == 8'd1) begin
						phase_d = PH_CRCLO;
					end
				end
				PH_LEN: begin
					len_d   = b;
					crc_d   = crc_next;
					left_d  = b;
					phase_d = (b == 8'h00) ? PH_CRCLO : PH_STR;
				end
				PH_STR: begin
					crc_d     = crc_next;
					left_d    = left_q - 8'd1;
					if (left_q == 8'd1) begin
						phase_d = PH_CRCLO;
					end
					res_valid = 1'b1;
					kind      = KIND_STRING;
					sbyte     = b;
				end
				PH_CRCLO: begin
					crclo_d = b;
					phase_d = PH_CRCHI;
				end
				PH_CRCHI: begin
					phase_d   = PH_IDLE;
					res_valid = 1'b1;
					status    = ({b, crclo_q} == crc_q) ? ST_OK : ST_CRC_BAD;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	assign is_num = is_number_type(type_d);
	assign is_str = is_string_type(type_d);

	always_comb begin
		res.result_kind    = kind;
		res.string_byte    = sbyte;
		res.addr_byte      = addr_d;
		res.func_byte      = func_d;
		res.type_code      = type_d;
		res.number_value   = (kind == KIND_SUMMARY && is_num) ? value_d : 32'h0;
		res.string_length  = is_str ? len_d : 8'h00;
		res.status         = status;
		res.last           = (kind == KIND_SUMMARY);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			crc_q   <= 16'h0000;
			left_q  <= 8'h00;
			addr_q  <= 8'h00;
			func_q  <= 8'h00;
			type_q  <= 8'h00;
			value_q <= 32'h0;
			len_q   <= 8'h00;
			crclo_q <= 8'h00;
		end else if (step) begin
			phase_q <= phase_d;
			crc_q   <= crc_d;
			left_q  <= left_d;
			addr_q  <= addr_d;
			func_q  <= func_d;
			type_q  <= type_d;
			value_q <= value_d;
			len_q   <= len_d;
			crclo_q <= crclo_d;
		end
	end

`ifndef ASSERT_OFF
	a_string_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.result_kind == KIND_STRING) |->
			(res.status == ST_OK && !res.last && res.number_value == 32'h0))
		else $error("string beat carries summary fields");

	a_start_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(step && beat.frame_start) |=> (phase_q == PH_FUNC))
		else $error("frame start did not open a frame");

	a_crchi_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !beat.frame_start && phase_q == PH_CRCHI) |=>
			(phase_q == PH_IDLE))
		else $error("frame not closed after crc");

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(!beat.frame_start && phase_q == PH_IDLE) |-> !res_valid)
		else $error("result from an idle byte");
`endif

endmodule

// ----- src/rfp_out_reg.sv -----
`timescale 1ns / 1ps

module rfp_out_reg
	import rfp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	output logic    slot_free,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t res_q
);

	assign slot_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (slot_free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && load) begin
			res_q <= res;
		end
	end

endmodule

// ----- src/response_frame_parser_crc16_core.sv -----
`timescale 1ns / 1ps

// Response frame parser with CRC-16/ARC check. Takes one frame byte per beat and
// sustains one byte per clock cycle while results are taken; a byte passes an input
// register and then the result register, where its result is presented.
// The whole parse step, including the eight-bit CRC update, is combinational logic
// between those two registers. String bytes leave as single results; a summary
// with status closes each frame. A full output register stalls the input side.

module response_frame_parser_crc16_core
	import rfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  rx_byte,
	input  logic        frame_start,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [7:0]  string_byte,
	output logic [7:0]  addr_byte,
	output logic [7:0]  func_byte,
	output logic [7:0]  type_code,
	output logic [31:0] number_value,
	output logic [7:0]  string_length,
	output logic [1:0]  status,
	output logic        last
);

	logic     valid_s1;
	in_beat_t beat_s1;
	logic     slot_free;
	logic     step;
	logic     res_valid;
	result_t  res;
	result_t  res_q;

	assign step = valid_s1 && slot_free;

	rfp_in_reg u_in_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.take        (step),
		.valid_s1    (valid_s1),
		.beat_s1     (beat_s1)
	);

	rfp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.beat      (beat_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	rfp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && res_valid),
		.res       (res),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	assign result_kind    = res_q.result_kind;
	assign string_byte    = res_q.string_byte;
	assign addr_byte      = res_q.addr_byte;
	assign func_byte      = res_q.func_byte;
	assign type_code      = res_q.type_code;
	assign number_value   = res_q.number_value;
	assign string_length  = res_q.string_length;
	assign status         = res_q.status;
	assign last           = res_q.last;

endmodule
